// ===== hw/rtl/grr_pkg.sv =====
`timescale 1ns / 1ps

package grr_pkg;

   localparam int MAX_GLYPHS = 512;
   localparam int MAX_HEIGHT = 32;
   localparam int MAX_WIDTH  = 16;

   localparam int GLYPH_W  = $clog2(MAX_GLYPHS);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int STORE_AW = GLYPH_W + ROW_W;

   localparam int WMAX = (MAX_WIDTH < 16) ? MAX_WIDTH : 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] SPACE_CODE = 16'd32;

   typedef struct packed {
      logic [31:0] frame_base;
      logic [15:0] line_pitch;
      logic        depth16;
      logic [4:0]  glyph_width;
      logic [5:0]  glyph_height;
      logic [9:0]  glyph_count;
   } cfg_type;

   // one queued word from front to back: either a font row write or a character draw
   typedef struct packed {
      logic               is_load;
      logic [GLYPH_W-1:0] glyph;
      logic [ROW_W-1:0]   load_row;
      logic [15:0]        load_bits;
      logic [ROW_W-1:0]   h_last;
      logic [15:0]        row_mask;
      logic               blank;
      logic [31:0]        base_addr;
      logic [31:0]        fg_pixel;
      logic [31:0]        bg_pixel;
   } cmd_type;

endpackage

// ===== hw/rtl/grr_if.sv =====
`timescale 1ns / 1ps

interface grr_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [7:0]  cell_col;
   logic [6:0]  cell_row;
   logic [15:0] code_point;
   logic [31:0] fg_color;
   logic [31:0] bg_color;
   logic [4:0]  load_row_index;
   logic [15:0] load_row_bits;

   modport source (
      output valid, req_type, cell_col, cell_row, code_point, fg_color, bg_color,
             load_row_index, load_row_bits,
      input  ready
   );
   modport sink (
      input  valid, req_type, cell_col, cell_row, code_point, fg_color, bg_color,
             load_row_index, load_row_bits,
      output ready
   );
endinterface

interface grr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] write_address;
   logic [15:0] row_bits;
   logic [31:0] fg_pixel;
   logic [31:0] bg_pixel;
   logic        last_row;

   modport source (
      output valid, write_address, row_bits, fg_pixel, bg_pixel, last_row,
      input  ready
   );
   modport sink (
      input  valid, write_address, row_bits, fg_pixel, bg_pixel, last_row,
      output ready
   );
endinterface

// ===== hw/rtl/grr_queue.sv =====
`timescale 1ns / 1ps

module grr_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  grr_pkg::cmd_type push_data,
   output logic            full,
   input  logic            pop,
   output grr_pkg::cmd_type pop_data,
   output logic            empty
);
   import grr_pkg::*;

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/grr_front.sv =====
`timescale 1ns / 1ps

module grr_front (
   input  logic             clock,
   input  logic             reset,
   input  grr_pkg::cfg_type cfg,
   grr_req_if.sink          req_chan,
   output logic             q_push,
   output grr_pkg::cmd_type q_data,
   input  logic             q_full
);
   import grr_pkg::*;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL1,
      F_MUL2,
      F_PUSH
   } front_state_type;

   front_state_type state_ff;

   logic        is_draw_ff;
   logic [7:0]  col_ff;
   logic [6:0]  row_ff;
   logic [15:0] code_ff;
   logic [31:0] fg_ff;
   logic [31:0] bg_ff;
   logic [4:0]  lidx_ff;
   logic [15:0] lbits_ff;
   logic [12:0] rowh_ff;
   logic [14:0] coloff_ff;
   logic [28:0] rowoff_ff;

   logic [5:0]  h_eff;
   logic [4:0]  w_eff;
   logic [9:0]  cnt_eff;
   logic [15:0] code_map;
   logic [12:0] colw;
   logic        blank;
   logic        load_drop;
   logic        accept;

   function automatic logic [31:0] to_565(input logic [31:0] c);
      return {16'd0, c[23:19], c[15:10], c[7:3]};
   endfunction

   always_comb begin
      if (cfg.glyph_height == '0) begin
         h_eff = 6'd1;
      end else if (cfg.glyph_height > 6'(MAX_HEIGHT)) begin
         h_eff = 6'(MAX_HEIGHT);
      end else begin
         h_eff = cfg.glyph_height;
      end
      if (cfg.glyph_width == '0) begin
         w_eff = 5'd1;
      end else if (cfg.glyph_width > 5'(WMAX)) begin
         w_eff = 5'(WMAX);
      end else begin
         w_eff = cfg.glyph_width;
      end
      if (cfg.glyph_count == '0) begin
         cnt_eff = 10'd1;
      end else if (cfg.glyph_count > 10'(MAX_GLYPHS)) begin
         cnt_eff = 10'(MAX_GLYPHS);
      end else begin
         cnt_eff = cfg.glyph_count;
      end
   end

   // codes past the font fall back to glyph 0
   assign code_map  = (code_ff >= 16'(cnt_eff)) ? 16'd0 : code_ff;
   assign blank     = (code_map == SPACE_CODE) && (bg_ff == '0);
   assign colw      = 13'(col_ff) * 13'(w_eff);
   assign load_drop = !is_draw_ff && (code_ff >= 16'(MAX_GLYPHS));
   assign accept    = req_chan.valid && req_chan.ready;

   assign req_chan.ready = (state_ff == F_IDLE);
   assign q_push         = (state_ff == F_PUSH) && !q_full && !load_drop;

   always_comb begin
      q_data           = '0;
      q_data.is_load   = !is_draw_ff;
      q_data.load_row  = ROW_W'(lidx_ff);
      q_data.load_bits = lbits_ff;
      q_data.h_last    = ROW_W'(h_eff - 6'd1);
      q_data.row_mask  = ~(16'hffff >> w_eff);
      q_data.blank     = blank;
      q_data.base_addr = cfg.frame_base + 32'(rowoff_ff) + 32'(coloff_ff);
      if (is_draw_ff) begin
         q_data.glyph = code_map[GLYPH_W-1:0];
      end else begin
         q_data.glyph = code_ff[GLYPH_W-1:0];
      end
      if (blank) begin
         q_data.fg_pixel = '0;
         q_data.bg_pixel = '0;
      end else if (cfg.depth16) begin
         q_data.fg_pixel = to_565(fg_ff);
         q_data.bg_pixel = to_565(bg_ff);
      end else begin
         q_data.fg_pixel = fg_ff;
         q_data.bg_pixel = bg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  state_ff <= req_chan.req_type ? F_MUL1 : F_PUSH;
               end
            end
            F_MUL1: begin
               state_ff <= F_MUL2;
            end
            F_MUL2: begin
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (load_drop || !q_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
      if (accept) begin
         is_draw_ff <= req_chan.req_type;
         col_ff     <= req_chan.cell_col;
         row_ff     <= req_chan.cell_row;
         code_ff    <= req_chan.code_point;
         fg_ff      <= req_chan.fg_color;
         bg_ff      <= req_chan.bg_color;
         lidx_ff    <= req_chan.load_row_index;
         lbits_ff   <= req_chan.load_row_bits;
      end
      if (state_ff == F_MUL1) begin
         rowh_ff   <= 13'(row_ff) * 13'(h_eff);
         coloff_ff <= cfg.depth16 ? {1'b0, colw, 1'b0} : {colw, 2'b00};
      end
      if (state_ff == F_MUL2) begin
         rowoff_ff <= 29'(rowh_ff) * 29'(cfg.line_pitch);
      end
   end

endmodule

// ===== hw/rtl/grr_back.sv =====
`timescale 1ns / 1ps

module grr_back (
   input  logic             clock,
   input  logic             reset,
   input  grr_pkg::cfg_type cfg,
   input  grr_pkg::cmd_type head,
   input  logic             q_empty,
   output logic             q_pop,
   grr_rsp_if.source        rsp_chan
);
   import grr_pkg::*;

   logic [15:0]         font_mem [2**STORE_AW];
   logic [15:0]         rd_data_ff;

   logic [ROW_W-1:0]    row_ff, row_in;
   logic [31:0]         addr_ff;
   logic [31:0]         addr_cur;

   logic                s1_valid_ff, s1_valid_in;
   logic [31:0]         s1_addr_ff;
   logic                s1_last_ff;
   logic                s1_blank_ff;
   logic [15:0]         s1_mask_ff;
   logic [31:0]         s1_fg_ff;
   logic [31:0]         s1_bg_ff;

   logic                out_valid_ff, out_valid_in;
   logic [31:0]         out_addr_ff;
   logic [15:0]         out_bits_ff;
   logic [31:0]         out_fg_ff;
   logic [31:0]         out_bg_ff;
   logic                out_last_ff;

   logic                out_free, s1_move, s1_free;
   logic                issue, load_wr, last_issue;

   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign s1_move    = s1_valid_ff && out_free;
   assign s1_free    = !s1_valid_ff || s1_move;
   assign load_wr    = !q_empty && head.is_load;
   assign issue      = !q_empty && !head.is_load && s1_free;
   assign last_issue = issue && (row_ff == head.h_last);
   assign q_pop      = load_wr || last_issue;

   assign addr_cur = (row_ff == '0) ? head.base_addr : addr_ff;

   always_comb begin
      row_in       = row_ff;
      if (issue) begin
         row_in = last_issue ? '0 : row_ff + 1'b1;
      end
      s1_valid_in  = issue ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (load_wr) begin
         font_mem[{head.glyph, head.load_row}] <= head.load_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= font_mem[{head.glyph, row_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         addr_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (issue) begin
            addr_ff <= addr_cur + 32'(cfg.line_pitch);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_addr_ff  <= addr_cur;
         s1_last_ff  <= (row_ff == head.h_last);
         s1_blank_ff <= head.blank;
         s1_mask_ff  <= head.row_mask;
         s1_fg_ff    <= head.fg_pixel;
         s1_bg_ff    <= head.bg_pixel;
      end
      if (s1_move) begin
         out_addr_ff <= s1_addr_ff;
         out_bits_ff <= s1_blank_ff ? 16'd0 : (rd_data_ff & s1_mask_ff);
         out_fg_ff   <= s1_fg_ff;
         out_bg_ff   <= s1_bg_ff;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.write_address = out_addr_ff;
   assign rsp_chan.row_bits      = out_bits_ff;
   assign rsp_chan.fg_pixel      = out_fg_ff;
   assign rsp_chan.bg_pixel      = out_bg_ff;
   assign rsp_chan.last_row      = out_last_ff;

endmodule

// ===== hw/rtl/glyph_row_renderer.sv =====
`timescale 1ns / 1ps

// Text-mode character generator for a linear framebuffer.
// req_chan takes one word per item: a font load (req_type 0) writes one glyph
// scanline into the font store and gives no result; a draw (req_type 1) gives
// one rsp_chan word per glyph scanline, last_row marking the final one.
// Registers are written over the csr_ APB port (4-byte stride); the user must
// write them only while idle; the block itself does not enforce this.
// Front: an input stage takes one item at a time, stepping a draw through its
// F_MUL1 and F_MUL2 address multiply states, a load skipping them, and hands
// it to a 4-word queue, waiting in F_PUSH while it is full. Back: one scanline
// per cycle from the single-port font store while rsp_chan takes words, so a
// draw occupies it for one read per scanline and a load for one write.
// Reset clears control state and restores register defaults; the font store
// is not cleared and must be loaded before drawing.
// When rsp_chan stalls, the output register and one read stage hold their
// words, the back stops issuing, and a full queue keeps req_chan ready low.
module glyph_row_renderer (
   input  logic        clock,
   input  logic        reset,
   grr_req_if.sink     req_chan,
   grr_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import grr_pkg::*;

   localparam logic [2:0] REG_FRAME_BASE   = 3'd0;
   localparam logic [2:0] REG_LINE_PITCH   = 3'd1;
   localparam logic [2:0] REG_DEPTH16      = 3'd2;
   localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd3;
   localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd4;
   localparam logic [2:0] REG_GLYPH_COUNT  = 3'd5;

   cfg_type     cfg_ff;
   logic [2:0]  reg_index;
   logic        csr_write;

   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_empty;
   cmd_type     q_push_data;
   cmd_type     q_head;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_base   <= 32'd0;
         cfg_ff.line_pitch   <= 16'd4096;
         cfg_ff.depth16      <= 1'b0;
         cfg_ff.glyph_width  <= 5'd8;
         cfg_ff.glyph_height <= 6'd16;
         cfg_ff.glyph_count  <= 10'd256;
      end else if (csr_write) begin
         case (reg_index)
            REG_FRAME_BASE:   cfg_ff.frame_base   <= csr_pwdata;
            REG_LINE_PITCH:   cfg_ff.line_pitch   <= csr_pwdata[15:0];
            REG_DEPTH16:      cfg_ff.depth16      <= csr_pwdata[0];
            REG_GLYPH_WIDTH:  cfg_ff.glyph_width  <= csr_pwdata[4:0];
            REG_GLYPH_HEIGHT: cfg_ff.glyph_height <= csr_pwdata[5:0];
            REG_GLYPH_COUNT:  cfg_ff.glyph_count  <= csr_pwdata[9:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_FRAME_BASE:   csr_prdata = cfg_ff.frame_base;
         REG_LINE_PITCH:   csr_prdata = 32'(cfg_ff.line_pitch);
         REG_DEPTH16:      csr_prdata = 32'(cfg_ff.depth16);
         REG_GLYPH_WIDTH:  csr_prdata = 32'(cfg_ff.glyph_width);
         REG_GLYPH_HEIGHT: csr_prdata = 32'(cfg_ff.glyph_height);
         REG_GLYPH_COUNT:  csr_prdata = 32'(cfg_ff.glyph_count);
         default:          csr_prdata = 32'd0;
      endcase
   end

   grr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .q_push   (q_push),
      .q_data   (q_push_data),
      .q_full   (q_full)
   );

   grr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_head),
      .empty     (q_empty)
   );

   grr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue pushed while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   a_front_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("front took a second word while busy");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result word valid right after reset");

endmodule

// ===== tb/sv/glyph_row_checker.sv =====
`timescale 1ns / 1ps

package grr_tb_pkg;

   typedef enum logic [2:0] {
      REG_FRAME_BASE,
      REG_LINE_PITCH,
      REG_DEPTH16,
      REG_GLYPH_WIDTH,
      REG_GLYPH_HEIGHT,
      REG_GLYPH_COUNT
   } csr_index_e;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DRAW = 1'b1;

endpackage

module glyph_row_checker (
   input  logic        clock,
   input  logic        reset,
   grr_req_if          req_mon,
   grr_rsp_if          rsp_mon,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          row_errors,
   output int          rows_outstanding
);

   import grr_pkg::*;
   import grr_tb_pkg::*;

   typedef struct packed {
      logic [31:0] write_address;
      logic [15:0] row_bits;
      logic [31:0] fg_pixel;
      logic [31:0] bg_pixel;
      logic        last_row;
   } row_word_t;

   cfg_type     cfg;
   logic [15:0] font_mem [MAX_GLYPHS*MAX_HEIGHT];
   row_word_t   awaited_rows [$];
   row_word_t   head_row;
   int          bad_fields;

   function automatic logic [31:0] to_rgb565(input logic [31:0] color);
      return {16'h0, color[23:19], color[15:10], color[7:3]};
   endfunction

   // queues one expected word per glyph scanline of a draw
   function automatic void render_glyph(input logic [7:0] col, input logic [6:0] row,
                                        input logic [15:0] code, input logic [31:0] fg,
                                        input logic [31:0] bg);
      int unsigned height;
      int unsigned width;
      int unsigned count;
      int unsigned glyph;
      int unsigned px_bytes;
      logic [15:0] mask;
      logic        blank;
      logic [31:0] fg_px;
      logic [31:0] bg_px;
      logic [31:0] addr;
      row_word_t   word;
      height = cfg.glyph_height;
      if (height == 0) height = 1;
      if (height > MAX_HEIGHT) height = MAX_HEIGHT;
      width = cfg.glyph_width;
      if (width == 0) width = 1;
      if (width > WMAX) width = WMAX;
      count = cfg.glyph_count;
      if (count == 0) count = 1;
      if (count > MAX_GLYPHS) count = MAX_GLYPHS;
      glyph = (code >= count) ? 0 : code;
      px_bytes = cfg.depth16 ? 2 : 4;
      mask = 16'(32'hFFFF << (16 - width));
      // blank compare uses the full 32-bit background, not just the RGB bits
      blank = (glyph == SPACE_CODE) && (bg == 32'h0);
      fg_px = cfg.depth16 ? to_rgb565(fg) : fg;
      bg_px = cfg.depth16 ? to_rgb565(bg) : bg;
      if (blank) begin
         fg_px = 32'h0;
         bg_px = 32'h0;
      end
      addr = cfg.frame_base + row * height * cfg.line_pitch + col * width * px_bytes;
      for (int r = 0; r < height; r++) begin
         word.write_address = addr;
         word.row_bits      = blank ? 16'h0 : (font_mem[glyph*MAX_HEIGHT + r] & mask);
         word.fg_pixel      = fg_px;
         word.bg_pixel      = bg_px;
         word.last_row      = (r == height - 1);
         awaited_rows.push_back(word);
         addr = addr + cfg.line_pitch;
      end
   endfunction

   function automatic int diff_field(input string label, input logic [31:0] want,
                                     input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, label, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg = '{32'h0, 16'd4096, 1'b0, 5'd8, 6'd16, 10'd256};
         awaited_rows.delete();
         row_errors <= 0;
         rows_outstanding <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_e'(csr_paddr[4:2]))
               REG_FRAME_BASE:   cfg.frame_base   = csr_pwdata;
               REG_LINE_PITCH:   cfg.line_pitch   = csr_pwdata[15:0];
               REG_DEPTH16:      cfg.depth16      = csr_pwdata[0];
               REG_GLYPH_WIDTH:  cfg.glyph_width  = csr_pwdata[4:0];
               REG_GLYPH_HEIGHT: cfg.glyph_height = csr_pwdata[5:0];
               REG_GLYPH_COUNT:  cfg.glyph_count  = csr_pwdata[9:0];
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.req_type == REQ_DRAW) begin
               render_glyph(req_mon.cell_col, req_mon.cell_row, req_mon.code_point,
                            req_mon.fg_color, req_mon.bg_color);
            end else if (req_mon.code_point < MAX_GLYPHS &&
                         req_mon.load_row_index < MAX_HEIGHT) begin
               font_mem[req_mon.code_point*MAX_HEIGHT + req_mon.load_row_index] =
                  req_mon.load_row_bits;
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_rows.size() == 0) begin
               $display("%0t: unexpected row word: address 0x%0h, bits 0x%0h",
                        $time, rsp_mon.write_address, rsp_mon.row_bits);
               row_errors <= row_errors + 1;
            end else begin
               head_row = awaited_rows.pop_front();
               bad_fields = diff_field("write_address", head_row.write_address,
                                       rsp_mon.write_address)
                          + diff_field("row_bits", 32'(head_row.row_bits),
                                       32'(rsp_mon.row_bits))
                          + diff_field("fg_pixel", head_row.fg_pixel, rsp_mon.fg_pixel)
                          + diff_field("bg_pixel", head_row.bg_pixel, rsp_mon.bg_pixel)
                          + diff_field("last_row", 32'(head_row.last_row),
                                       32'(rsp_mon.last_row));
               if (bad_fields != 0) row_errors <= row_errors + 1;
            end
         end

         rows_outstanding <= awaited_rows.size();
      end
   end

endmodule

// ===== tb/sv/glyph_row_renderer_test.sv =====
`timescale 1ns / 1ps

module glyph_row_renderer_test;

   import grr_pkg::*;
   import grr_tb_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 14;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

   typedef struct {
      logic        kind;
      logic [7:0]  col;
      logic [6:0]  row;
      logic [15:0] code;
      logic [31:0] fg;
      logic [31:0] bg;
      logic [4:0]  load_idx;
      logic [15:0] load_bits;
   } req_word_t;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          row_errors;
   int          rows_outstanding;
   int          send_gap_pct = 0;
   int          stall_pct = 0;
   int          cycle_count = 0;
   int          items_sent = 0;
   int unsigned eff_height;
   int unsigned eff_count;
   bit          font_written [MAX_GLYPHS*MAX_HEIGHT];

   grr_req_if req_bus ();
   grr_rsp_if rsp_bus ();

   glyph_row_renderer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   glyph_row_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .row_errors       (row_errors),
      .rows_outstanding (rows_outstanding)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d row words outstanding",
                  $time, cycle_count, rows_outstanding);
         $display("Test completed with failures");
         $finish;
      end
   end

   // psel stays high between back-to-back writes; the caller drops it
   task automatic csr_write(input csr_index_e idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic apply_setup(input logic [31:0] base, input logic [15:0] pitch,
                              input logic d16, input logic [4:0] width,
                              input logic [5:0] height, input logic [9:0] count);
      csr_write(REG_FRAME_BASE, base);
      csr_write(REG_LINE_PITCH, 32'(pitch));
      csr_write(REG_DEPTH16, 32'(d16));
      csr_write(REG_GLYPH_WIDTH, 32'(width));
      csr_write(REG_GLYPH_HEIGHT, 32'(height));
      csr_write(REG_GLYPH_COUNT, 32'(count));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      eff_height = (height == 0) ? 1 : (height > MAX_HEIGHT) ? MAX_HEIGHT : height;
      eff_count  = (count == 0) ? 1 : (count > MAX_GLYPHS) ? MAX_GLYPHS : count;
   endtask

   task automatic set_idle(input idle_mode_e mode);
      case (mode)
         IDLE_NONE:     begin send_gap_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin send_gap_pct = 83; stall_pct = 0;  end
         IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 83; end
         default:       begin send_gap_pct = 29; stall_pct = 29; end
      endcase
   endtask

   task automatic send_word(input req_word_t w);
      if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_bus.valid          <= 1'b1;
      req_bus.req_type       <= w.kind;
      req_bus.cell_col       <= w.col;
      req_bus.cell_row       <= w.row;
      req_bus.code_point     <= w.code;
      req_bus.fg_color       <= w.fg;
      req_bus.bg_color       <= w.bg;
      req_bus.load_row_index <= w.load_idx;
      req_bus.load_row_bits  <= w.load_bits;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic load_row(input logic [15:0] glyph, input logic [4:0] idx,
                           input logic [15:0] bits);
      req_word_t w;
      w.kind      = REQ_LOAD;
      w.col       = 8'($urandom_range(255));
      w.row       = 7'($urandom_range(127));
      w.code      = glyph;
      w.fg        = $urandom;
      w.bg        = $urandom;
      w.load_idx  = idx;
      w.load_bits = bits;
      send_word(w);
      // out-of-range glyphs are dropped by the block and do not count
      if (glyph < MAX_GLYPHS) begin
         font_written[glyph*MAX_HEIGHT + idx] = 1'b1;
         items_sent++;
      end
   endtask

   task automatic draw_char(input logic [15:0] code, input logic [7:0] col,
                            input logic [6:0] row, input logic [31:0] fg,
                            input logic [31:0] bg);
      req_word_t w;
      w.kind      = REQ_DRAW;
      w.col       = col;
      w.row       = row;
      w.code      = code;
      w.fg        = fg;
      w.bg        = bg;
      w.load_idx  = 5'($urandom_range(31));
      w.load_bits = 16'($urandom_range(65535));
      send_word(w);
      items_sent++;
   endtask

   function automatic bit glyph_ready(input int unsigned glyph);
      for (int r = 0; r < eff_height; r++) begin
         if (!font_written[glyph*MAX_HEIGHT + r]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // falls back to the freshly loaded glyph if the pick would read unloaded rows
   function automatic logic [15:0] pick_code(input int unsigned fresh);
      logic [15:0] code;
      int unsigned glyph;
      case ($urandom_range(4))
         0, 1:    code = 16'(fresh);
         2:       code = SPACE_CODE;
         3:       code = 16'($urandom_range(65535));
         default: code = 16'($urandom_range(65535, eff_count));
      endcase
      glyph = (code >= eff_count) ? 0 : code;
      if (!glyph_ready(glyph)) code = 16'(fresh);
      return code;
   endfunction

   task automatic wait_drained(input int settle);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (rows_outstanding != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic random_traffic(input int budget, input bit pause_once);
      int          first;
      int unsigned glyph;
      int unsigned n_draws;
      bit          paused;
      first  = items_sent;
      paused = 1'b0;
      while (items_sent - first < budget) begin
         case ($urandom_range(5))
            0:       glyph = 0;
            1:       glyph = (SPACE_CODE < eff_count) ? SPACE_CODE : 0;
            default: glyph = $urandom_range(eff_count - 1);
         endcase
         // stray word, often to a glyph the block drops
         if ($urandom_range(3) == 0) begin
            load_row($urandom_range(1) ? 16'($urandom_range(MAX_GLYPHS - 1))
                                       : 16'($urandom_range(65535)),
                     5'($urandom_range(31)), 16'($urandom_range(65535)));
         end
         if (!glyph_ready(glyph) || $urandom_range(3) != 0) begin
            for (int r = 0; r < eff_height; r++) begin
               load_row(16'(glyph), 5'(r), 16'($urandom_range(65535)));
            end
         end
         n_draws = $urandom_range(3, 1);
         repeat (n_draws) begin
            draw_char(pick_code(glyph), 8'($urandom_range(255)), 7'($urandom_range(127)),
                      $urandom, ($urandom_range(3) == 0) ? 32'h0 : $urandom);
         end
         if (pause_once && !paused) begin
            wait_drained(0);
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      reset                  <= 1'b1;
      csr_psel               <= 1'b0;
      csr_penable            <= 1'b0;
      csr_pwrite             <= 1'b0;
      csr_paddr              <= '0;
      csr_pwdata             <= '0;
      req_bus.valid          <= 1'b0;
      req_bus.req_type       <= REQ_LOAD;
      req_bus.cell_col       <= '0;
      req_bus.cell_row       <= '0;
      req_bus.code_point     <= '0;
      req_bus.fg_color       <= '0;
      req_bus.bg_color       <= '0;
      req_bus.load_row_index <= '0;
      req_bus.load_row_bits  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: two-row glyphs so the font loads stay short
      apply_setup(32'h0, 16'd4096, 1'b0, 5'd8, 6'd2, 10'd512);
      set_idle(IDLE_NONE);
      load_row(16'd0, 5'd0, 16'hFFFF);
      load_row(16'd0, 5'd1, 16'h0000);
      load_row(16'd0, 5'd31, 16'h8001);
      load_row(SPACE_CODE, 5'd0, 16'hA5A5);
      load_row(SPACE_CODE, 5'd1, 16'h5A5A);
      load_row(16'd511, 5'd0, 16'h7FFE);
      load_row(16'd511, 5'd1, 16'hFFFF);
      load_row(16'hFFFF, 5'd31, 16'hFFFF);
      load_row(16'd512, 5'd0, 16'h0000);
      draw_char(16'd0, 8'd0, 7'd0, 32'h0, 32'h0);
      draw_char(16'd511, 8'd255, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      draw_char(16'd512, 8'd1, 7'd1, 32'h00FF_0000, 32'h0000_FF00);
      draw_char(16'hFFFF, 8'd17, 7'd3, 32'h0012_3456, 32'h00AB_CDEF);
      draw_char(SPACE_CODE, 8'd40, 7'd20, 32'h00FF_FFFF, 32'h0);
      draw_char(SPACE_CODE, 8'd41, 7'd20, 32'h00FF_FFFF, 32'h1);
      draw_char(SPACE_CODE, 8'd42, 7'd20, 32'h0, 32'hFF00_0000);
      wait_drained(SETTLE_CYCLES);

      apply_setup(32'h0, 16'd4096, 1'b0, 5'd8, 6'd16, 10'd256);
      set_idle(IDLE_NONE);
      random_traffic(PHASE_ITEMS, 1'b0);
      wait_drained(SETTLE_CYCLES);

      apply_setup(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 5'd16, 6'd4, 10'd512);
      set_idle(IDLE_SENDER);
      random_traffic(PHASE_ITEMS, 1'b1);
      wait_drained(SETTLE_CYCLES);

      apply_setup($urandom, 16'd1, 1'b0, 5'd1, 6'd1, 10'd1);
      set_idle(IDLE_RECEIVER);
      random_traffic(PHASE_ITEMS, 1'b0);
      wait_drained(SETTLE_CYCLES);

      // zero geometry and zero pitch
      apply_setup(32'h8000_0000, 16'd0, 1'b1, 5'd0, 6'd0, 10'd0);
      set_idle(IDLE_BOTH);
      random_traffic(PHASE_ITEMS, 1'b0);
      wait_drained(SETTLE_CYCLES);

      // every geometry register above its range
      apply_setup($urandom, 16'($urandom_range(65535, 1)), 1'b1, 5'd31, 6'd63, 10'd1023);
      set_idle(IDLE_NONE);
      random_traffic(PHASE_ITEMS, 1'b0);
      wait_drained(SETTLE_CYCLES);

      apply_setup($urandom, 16'($urandom_range(65535, 1)), 1'b0, 5'd5, 6'd3, 10'd100);
      set_idle(IDLE_SENDER);
      random_traffic(PHASE_ITEMS, 1'b0);
      wait_drained(SETTLE_CYCLES);

      apply_setup($urandom, 16'd640, 1'b1, 5'd9, 6'd8, 10'd300);
      set_idle(IDLE_RECEIVER);
      random_traffic(PHASE_ITEMS, 1'b0);
      wait_drained(SETTLE_CYCLES);

      apply_setup($urandom, 16'd2560, 1'b0, 5'd12, 6'd6, 10'd400);
      set_idle(IDLE_BOTH);
      random_traffic(PHASE_ITEMS, 1'b0);
      wait_drained(SETTLE_CYCLES);

      if (row_errors == 0 && rows_outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
